[design/sbb_pkg.sv]
// shared constants and types of the separable box blur
`timescale 1ns / 1ps
package sbb_pkg;
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAX_RADIUS = 15;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int PIX_W      = 32;
    localparam int RAD_W      = 4;
    localparam int DIM_W      = 8;
    localparam int SUM_W      = 13;
    localparam int OFS_W      = 6;
    localparam int BIT_W      = 3;
    localparam int PADDR_W    = 4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                    in_ready;
        logic                    load;
        logic                    rd;
        logic signed [OFS_W-1:0] dj;
        logic signed [OFS_W-1:0] dk;
        logic                    div_load_h;
        logic                    div_load_v;
        logic                    div_step;
        logic [BIT_W-1:0]        bit_idx;
        logic                    vadd;
        logic                    out_load;
    } t_cmd;

    typedef struct packed {
        logic             in_valid;
        logic             in_read;
        logic             in_inside;
        logic [RAD_W-1:0] radius;
        logic             out_busy;
    } t_sts;
endpackage

[design/sbb_if.sv]
// request and result channels of the blur block
`timescale 1ns / 1ps
interface sbb_in_if;
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [6:0]              col;
    logic [6:0]              row;
    logic [31:0]             pixel_in;
    modport source (output valid, action, col, row, pixel_in, input ready);
    modport sink   (input valid, action, col, row, pixel_in, output ready);
endinterface

interface sbb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic [6:0]  out_col;
    logic [6:0]  out_row;
    logic        range_error;
    modport source (output valid, pixel_out, out_col, out_row, range_error, input ready);
    modport sink   (input valid, pixel_out, out_col, out_row, range_error, output ready);
endinterface

[design/sbb_datapath.sv]
// frame store, window accumulators, shared divider, output register and config registers
`timescale 1ns / 1ps
module sbb_datapath import sbb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sbb_in_if.sink             i_in,
    sbb_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  t_cmd               i_cmd,
    output t_sts               o_sts
);
    logic [RAD_W-1:0] r_radius;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             accept;
    logic             inside_in;
    logic [COL_W-1:0] r_x;
    logic [ROW_W-1:0] r_y;
    logic             r_err;
    logic signed [COL_W+1:0] sx;
    logic signed [ROW_W+1:0] sy;
    logic [COL_W-1:0] xx;
    logic [ROW_W-1:0] yy;
    logic [PIX_W-1:0] r_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [PIX_W-1:0] r_mem_q;
    logic             r_rd_vld;
    logic [SUM_W-1:0] r_hsum [4];
    logic [SUM_W-1:0] r_vsum [4];
    logic [SUM_W-1:0] r_rem [4];
    logic [7:0]       r_q [4];
    logic [4:0]       cnt;
    logic [SUM_W-1:0] trial;
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_pix;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_err;

    // apb register file
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(1);
            r_width  <= DIM_W'(MAX_WIDTH);
            r_height <= DIM_W'(MAX_HEIGHT);
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_RADIUS: prdata = 32'(r_radius);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    assign w_eff = (r_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_width;
    assign h_eff = (r_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_height;

    assign i_in.ready = i_cmd.in_ready;
    assign accept     = i_in.valid && i_cmd.in_ready;
    assign inside_in  = (DIM_W'(i_in.col) < w_eff) && (DIM_W'(i_in.row) < h_eff);

    assign o_sts.in_valid  = i_in.valid;
    assign o_sts.in_read   = (i_in.action == ACT_READ);
    assign o_sts.in_inside = inside_in;
    assign o_sts.radius    = r_radius;
    assign o_sts.out_busy  = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_in.col;
            r_y   <= i_in.row;
            r_err <= !inside_in;
        end
    end

    // edge-replicating clamp of the window position
    assign sx = $signed({2'b00, r_x}) + (COL_W+2)'(i_cmd.dj);
    assign sy = $signed({2'b00, r_y}) + (ROW_W+2)'(i_cmd.dk);
    always_comb begin
        if (sx < 0)
            xx = '0;
        else if (sx >= $signed((COL_W+2)'(w_eff)))
            xx = COL_W'(w_eff - DIM_W'(1));
        else
            xx = sx[COL_W-1:0];
        if (sy < 0)
            yy = '0;
        else if (sy >= $signed((ROW_W+2)'(h_eff)))
            yy = ROW_W'(h_eff - DIM_W'(1));
        else
            yy = sy[ROW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.action == ACT_WRITE && inside_in)
            r_mem[{i_in.row, i_in.col}] <= i_in.pixel_in;
        if (i_cmd.rd)
            r_mem_q <= r_mem[{yy, xx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_rd_vld <= 1'b0;
        else
            r_rd_vld <= i_cmd.rd;
    end

    assign cnt   = {r_radius, 1'b1};
    assign trial = SUM_W'(cnt) << i_cmd.bit_idx;

    // per-channel sums and restoring divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            if (i_cmd.load || i_cmd.div_load_h)
                r_hsum[c] <= '0;
            else if (r_rd_vld)
                r_hsum[c] <= r_hsum[c] + SUM_W'(r_mem_q[8*c +: 8]);

            if (i_cmd.load)
                r_vsum[c] <= '0;
            else if (i_cmd.vadd)
                r_vsum[c] <= r_vsum[c] + SUM_W'(r_q[c]);

            if (i_cmd.div_load_h) begin
                r_rem[c] <= r_hsum[c];
                r_q[c]   <= '0;
            end else if (i_cmd.div_load_v) begin
                r_rem[c] <= r_vsum[c];
                r_q[c]   <= '0;
            end else if (i_cmd.div_step && r_rem[c] >= trial) begin
                r_rem[c]               <= r_rem[c] - trial;
                r_q[c][i_cmd.bit_idx]  <= 1'b1;
            end
        end
    end

    // output register, frees the input side while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_vld <= 1'b0;
        else if (i_cmd.out_load)
            r_out_vld <= 1'b1;
        else if (o_out.ready)
            r_out_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pix <= r_err ? '0 : {r_q[3], r_q[2], r_q[1], r_q[0]};
            r_out_col <= r_x;
            r_out_row <= r_y;
            r_out_err <= r_err;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.pixel_out   = r_out_pix;
    assign o_out.out_col     = r_out_col;
    assign o_out.out_row     = r_out_row;
    assign o_out.range_error = r_out_err;
endmodule

[design/sbb_ctrl.sv]
// sequencer walking the blur window row by row
`timescale 1ns / 1ps
module sbb_ctrl import sbb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_ROWRD, ST_DRAIN, ST_HLOAD, ST_HDIV,
        ST_VACC, ST_VLOAD, ST_VDIV, ST_OUT
    } t_state;

    t_state                  r_state;
    logic signed [OFS_W-1:0] r_j;
    logic signed [OFS_W-1:0] r_k;
    logic [BIT_W-1:0]        r_bit;
    logic signed [OFS_W-1:0] rad;

    assign rad = $signed(OFS_W'(i_sts.radius));

    always_comb begin
        o_cmd            = '0;
        o_cmd.dj         = r_j;
        o_cmd.dk         = r_k;
        o_cmd.bit_idx    = r_bit;
        o_cmd.in_ready   = (r_state == ST_IDLE);
        o_cmd.load       = (r_state == ST_IDLE) && i_sts.in_valid;
        o_cmd.rd         = (r_state == ST_ROWRD);
        o_cmd.div_load_h = (r_state == ST_HLOAD);
        o_cmd.div_load_v = (r_state == ST_VLOAD);
        o_cmd.div_step   = (r_state == ST_HDIV) || (r_state == ST_VDIV);
        o_cmd.vadd       = (r_state == ST_VACC);
        o_cmd.out_load   = (r_state == ST_OUT) && !i_sts.out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
            r_k     <= '0;
            r_bit   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_sts.in_valid && i_sts.in_read) begin
                        r_j <= -rad;
                        r_k <= -rad;
                        r_state <= i_sts.in_inside ? ST_ROWRD : ST_OUT;
                    end
                end
                ST_ROWRD: begin
                    if (r_j == rad)
                        r_state <= ST_DRAIN;
                    else
                        r_j <= r_j + OFS_W'(1);
                end
                ST_DRAIN: r_state <= ST_HLOAD;
                ST_HLOAD: begin
                    r_bit   <= BIT_W'(7);
                    r_state <= ST_HDIV;
                end
                ST_HDIV: begin
                    if (r_bit == '0)
                        r_state <= ST_VACC;
                    else
                        r_bit <= r_bit - BIT_W'(1);
                end
                ST_VACC: begin
                    if (r_k == rad) begin
                        r_state <= ST_VLOAD;
                    end else begin
                        r_k     <= r_k + OFS_W'(1);
                        r_j     <= -rad;
                        r_state <= ST_ROWRD;
                    end
                end
                ST_VLOAD: begin
                    r_bit   <= BIT_W'(7);
                    r_state <= ST_VDIV;
                end
                ST_VDIV: begin
                    if (r_bit == '0)
                        r_state <= ST_OUT;
                    else
                        r_bit <= r_bit - BIT_W'(1);
                end
                ST_OUT: begin
                    if (!i_sts.out_busy)
                        r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

[design/separable_box_blur.sv]
// top level of the separable box blur
`timescale 1ns / 1ps
// Box blur with edge clamp over a 128x128 ARGB32 frame store. A write request
// stores a pixel when it is accepted. A read request walks the (2r+1) x (2r+1)
// window one stored pixel a cycle through the single memory read port, and each
// window row plus the final column pass goes through a shared divider. An
// out-of-range read skips the window and returns range_error with a zero pixel.
// The result sits in an output register, so the next request is taken while it
// waits. Pixels must be written before any read window covers them.
module separable_box_blur import sbb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sbb_in_if.sink             i_in,
    sbb_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    t_cmd cmd;
    t_sts sts;

    sbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sbb_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule

[design/sbb_checker.sv]
// port-level checks of the blur block
`timescale 1ns / 1ps
module sbb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] pixel_out,
    input logic        range_error,
    input logic        pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out))
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && range_error |-> pixel_out == 32'd0)
        else $error("error result carries pixel data");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result produced while idle");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");
endmodule

bind separable_box_blur sbb_checker u_sbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_ready    (i_in.ready),
    .out_valid   (o_out.valid),
    .out_ready   (o_out.ready),
    .pixel_out   (o_out.pixel_out),
    .range_error (o_out.range_error),
    .pready      (pready)
);
